// ----- hdl/cdum_pkg.sv -----
// Shared types, widths and calendar tables for the civil date to epoch converter.
package cdum_pkg;

  localparam int unsigned NUM_STAGES  = 7;
  localparam int unsigned DAYS_STAGES = 5;
  localparam int unsigned DAYS_W      = 25;
  localparam int unsigned TOD_MS_W    = 27;
  localparam int unsigned OUT_DAYS_W  = 23;
  localparam int unsigned OUT_MS_W    = 49;

  localparam logic [15:0] YEAR_BIAS      = 16'd16400;
  localparam logic [6:0]  ERA_BIAS       = 7'd41;
  localparam logic [11:0] DIV25_RECIP    = 12'd2622;
  localparam logic [15:0] YEARS_PER_ERA  = 16'd400;
  localparam logic [17:0] DAYS_PER_YEAR  = 18'd365;
  localparam logic signed [24:0] DAYS_PER_ERA = 25'sd146097;
  localparam logic signed [24:0] EPOCH_SHIFT  = 25'sd719468;
  localparam logic signed [27:0] MS_PER_DAY   = 28'sd86400000;

  // Stage advance enables for the day-count half of the pipeline.
  typedef struct packed {
    logic [DAYS_STAGES-1:0] adv;
  } days_ctl_t;

  // Days from March 1 to the first of the given month, March-based year.
  function automatic logic [8:0] month_base(input logic [3:0] month);
    logic [8:0] base;
    unique case (month)
      4'd0:    base = 9'd275;
      4'd1:    base = 9'd306;
      4'd2:    base = 9'd337;
      4'd3:    base = 9'd0;
      4'd4:    base = 9'd31;
      4'd5:    base = 9'd61;
      4'd6:    base = 9'd92;
      4'd7:    base = 9'd122;
      4'd8:    base = 9'd153;
      4'd9:    base = 9'd184;
      4'd10:   base = 9'd214;
      4'd11:   base = 9'd245;
      4'd12:   base = 9'd275;
      4'd13:   base = 9'd306;
      4'd14:   base = 9'd337;
      default: base = 9'd367;
    endcase
    return base;
  endfunction

  // Whole centuries in a year of era (0 to 399).
  function automatic logic [1:0] yoe_century(input logic [8:0] yoe);
    logic [1:0] cent;
    priority if (yoe >= 9'd300) begin
      cent = 2'd3;
    end else if (yoe >= 9'd200) begin
      cent = 2'd2;
    end else if (yoe >= 9'd100) begin
      cent = 2'd1;
    end else begin
      cent = 2'd0;
    end
    return cent;
  endfunction

endpackage

// ----- hdl/cdum_days_pipe.sv -----
// Five-stage day-count datapath: era split, year of era and day of era.
module cdum_days_pipe (
  input  logic                                 clk,
  input  cdum_pkg::days_ctl_t                  ctl,
  input  logic signed [14:0]                   cal_year,
  input  logic [3:0]                           cal_month,
  input  logic [4:0]                           cal_day,
  output logic signed [cdum_pkg::DAYS_W-1:0]   days
);

  // Stage 0: shift to a March-based year and bias it non-negative.
  logic               early_s;
  logic signed [15:0] year_s;
  logic signed [15:0] yadj_s;
  logic [15:0]        ubias_s;
  logic signed [10:0] doy_s;
  logic [15:0]        u0_r;
  logic signed [10:0] doy0_r;

  assign early_s = (cal_month <= 4'd2);
  assign year_s  = {cal_year[14], cal_year};
  assign yadj_s  = early_s ? (year_s - 16'sd1) : year_s;
  assign ubias_s = yadj_s + cdum_pkg::YEAR_BIAS;
  assign doy_s   = $signed({2'b00, cdum_pkg::month_base(cal_month)})
                 + $signed({6'b000000, cal_day}) - 11'sd1;

  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      u0_r   <= ubias_s;
      doy0_r <= doy_s;
    end
  end

  // Stage 1: divide the biased year by 400 as (u / 16) / 25 with a reciprocal.
  logic [23:0]        div_prod_s;
  logic [6:0]         q1_r;
  logic [15:0]        u1_r;
  logic signed [10:0] doy1_r;

  assign div_prod_s = u0_r[15:4] * cdum_pkg::DIV25_RECIP;

  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      q1_r   <= div_prod_s[22:16];
      u1_r   <= u0_r;
      doy1_r <= doy0_r;
    end
  end

  // Stage 2: remainder is the year of era; the bias is a whole number of eras.
  logic [15:0]        q400_s;
  logic [15:0]        rem_s;
  logic [7:0]         era_s;
  logic [8:0]         yoe2_r;
  logic signed [6:0]  era2_r;
  logic signed [10:0] doy2_r;

  assign q400_s = {9'd0, q1_r} * cdum_pkg::YEARS_PER_ERA;
  assign rem_s  = u1_r - q400_s;
  assign era_s  = {1'b0, q1_r} - {1'b0, cdum_pkg::ERA_BIAS};

  always_ff @(posedge clk) begin
    if (ctl.adv[2]) begin
      yoe2_r <= rem_s[8:0];
      era2_r <= $signed(era_s[6:0]);
      doy2_r <= doy1_r;
    end
  end

  // Stage 3: day of era and the era's day offset, side by side.
  logic [17:0]        yoe365_s;
  logic signed [19:0] doe_s;
  logic signed [24:0] era_days_s;
  logic signed [19:0] doe3_r;
  logic signed [24:0] era_days3_r;

  assign yoe365_s   = 18'(yoe2_r) * cdum_pkg::DAYS_PER_YEAR;
  assign doe_s      = $signed({2'b00, yoe365_s})
                    + $signed({13'd0, yoe2_r[8:2]})
                    - $signed({18'd0, cdum_pkg::yoe_century(yoe2_r)})
                    + $signed({{9{doy2_r[10]}}, doy2_r});
  assign era_days_s = 25'(era2_r) * cdum_pkg::DAYS_PER_ERA;

  always_ff @(posedge clk) begin
    if (ctl.adv[3]) begin
      doe3_r      <= doe_s;
      era_days3_r <= era_days_s;
    end
  end

  // Stage 4: move the origin to 1970-01-01.
  logic signed [cdum_pkg::DAYS_W-1:0] days4_r;

  always_ff @(posedge clk) begin
    if (ctl.adv[4]) begin
      days4_r <= era_days3_r + 25'(doe3_r) - cdum_pkg::EPOCH_SHIFT;
    end
  end

  assign days = days4_r;

endmodule

// ----- hdl/civil_datetime_to_unix_ms.sv -----
// Top level: civil UTC date and time to epoch days and epoch milliseconds.
//
//   channel  direction  handshake             payload
//   in_      input      in_valid / in_ready   cal_year .. clock_millis
//   out_     output     out_valid / out_ready epoch_days, epoch_millis
//
// Seven register stages; an item enters every cycle when nothing stalls, and
// its result reaches the output after passing through each stage in turn.
// Each stage holds while the stage after it is full and stalled, so bubbles
// are squeezed out and in_ready only drops when every stage is occupied.
// Reset (rst_n low at a clock edge) empties the pipeline; data registers
// are not cleared.
module civil_datetime_to_unix_ms (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [14:0] in_cal_year,
  input  logic [3:0]         in_cal_month,
  input  logic [4:0]         in_cal_day,
  input  logic [4:0]         in_clock_hour,
  input  logic [5:0]         in_clock_minute,
  input  logic [5:0]         in_clock_second,
  input  logic [9:0]         in_clock_millis,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [22:0] out_epoch_days,
  output logic signed [48:0] out_epoch_millis
);

  localparam int unsigned NS = cdum_pkg::NUM_STAGES;
  localparam int unsigned DS = cdum_pkg::DAYS_STAGES;

  logic [NS-1:0] vld_r;
  logic [NS-1:0] adv;

  // A stage loads when it is empty or its content moves on this cycle.
  always_comb begin
    adv[NS-1] = ~vld_r[NS-1] | out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = ~vld_r[i] | adv[i+1];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Date half of the pipeline.
  cdum_pkg::days_ctl_t               days_ctl;
  logic signed [cdum_pkg::DAYS_W-1:0] days4;

  assign days_ctl.adv = adv[DS-1:0];

  cdum_days_pipe u_days (
    .clk       (clk),
    .ctl       (days_ctl),
    .cal_year  (in_cal_year),
    .cal_month (in_cal_month),
    .cal_day   (in_cal_day),
    .days      (days4)
  );

  // Time of day, carried alongside the day count.
  logic [16:0] tod_s;
  logic [16:0] tod0_r;
  logic [9:0]  millis0_r;
  logic [cdum_pkg::TOD_MS_W-1:0] tod_ms_r [1:DS];

  assign tod_s = 17'(in_clock_hour) * 17'd3600
               + 17'(in_clock_minute) * 17'd60
               + 17'(in_clock_second);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      tod0_r    <= tod_s;
      millis0_r <= in_clock_millis;
    end
    if (adv[1]) begin
      tod_ms_r[1] <= 27'(tod0_r) * 27'd1000 + 27'(millis0_r);
    end
    for (int i = 2; i <= DS; i++) begin
      if (adv[i]) begin
        tod_ms_r[i] <= tod_ms_r[i-1];
      end
    end
  end

  // Stage 5: scale days to milliseconds; only the low result bits are kept.
  logic signed [52:0] day_ms_s;
  logic [cdum_pkg::OUT_MS_W-1:0]   day_ms5_r;
  logic [cdum_pkg::OUT_DAYS_W-1:0] days5_r;

  assign day_ms_s = days4 * cdum_pkg::MS_PER_DAY;

  always_ff @(posedge clk) begin
    if (adv[DS]) begin
      day_ms5_r <= day_ms_s[cdum_pkg::OUT_MS_W-1:0];
      days5_r   <= days4[cdum_pkg::OUT_DAYS_W-1:0];
    end
  end

  // Stage 6: output register.
  logic [cdum_pkg::OUT_MS_W-1:0]   millis6_r;
  logic [cdum_pkg::OUT_DAYS_W-1:0] days6_r;

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      millis6_r <= day_ms5_r + {22'd0, tod_ms_r[DS]};
      days6_r   <= days5_r;
    end
  end

  assign out_epoch_days   = $signed(days6_r);
  assign out_epoch_millis = $signed(millis6_r);

endmodule

// ----- verif/tb.sv -----
// Testbench for the civil date and time to epoch days and milliseconds converter.
`timescale 1ns / 100ps

module tb;

  localparam longint DAYS_IN_ERA   = 146097;
  localparam longint DAY_OF_EPOCH  = 719468;
  localparam longint MS_IN_SECOND  = 1000;
  localparam int     CYCLE_LIMIT   = 200000;
  localparam int     QUIET_TAIL    = 80;
  localparam int     RANDOM_STAMPS = 650;

  typedef struct {
    logic signed [14:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [5:0]         second;
    logic [9:0]         millis;
    bit                 drain_first;
  } stamp_t;

  typedef struct {
    logic signed [cdum_pkg::OUT_DAYS_W-1:0] days;
    logic signed [cdum_pkg::OUT_MS_W-1:0]   millis;
  } epoch_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [14:0] in_cal_year = '0;
  logic [3:0] in_cal_month = '0;
  logic [4:0] in_cal_day = '0;
  logic [4:0] in_clock_hour = '0;
  logic [5:0] in_clock_minute = '0;
  logic [5:0] in_clock_second = '0;
  logic [9:0] in_clock_millis = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [cdum_pkg::OUT_DAYS_W-1:0] out_epoch_days;
  logic signed [cdum_pkg::OUT_MS_W-1:0] out_epoch_millis;

  stamp_t stamps_pending[$];
  epoch_t epochs_expected[$];
  int total_stamps = 0;
  int sent_count = 0;
  int got_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int bad_count = 0;
  int cycles = 0;

  civil_datetime_to_unix_ms dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cal_year      (in_cal_year),
    .in_cal_month     (in_cal_month),
    .in_cal_day       (in_cal_day),
    .in_clock_hour    (in_clock_hour),
    .in_clock_minute  (in_clock_minute),
    .in_clock_second  (in_clock_second),
    .in_clock_millis  (in_clock_millis),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_epoch_days   (out_epoch_days),
    .out_epoch_millis (out_epoch_millis)
  );

  always #6 clk = ~clk;

  // Days since 1970-01-01 by the March-based era method, then milliseconds,
  // both computed exactly in 64 bits and wrapped to the port widths.
  function automatic epoch_t civil_to_epoch(input stamp_t s);
    longint y, m, era, yoe, mshift, doy, doe, days, ms;
    epoch_t r;
    y = s.year;
    m = s.month;
    if (m <= 2) begin
      y = y - 1;
    end
    era = ((y >= 0) ? y : y - 399) / 400;
    yoe = y - era * 400;
    mshift = (m > 2) ? m - 3 : m + 9;
    doy = (153 * mshift + 2) / 5 + longint'(s.day) - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * DAYS_IN_ERA + doe - DAY_OF_EPOCH;
    ms = (((days * 24 + longint'(s.hour)) * 60 + longint'(s.minute)) * 60
          + longint'(s.second)) * MS_IN_SECOND + longint'(s.millis);
    r.days = days[cdum_pkg::OUT_DAYS_W-1:0];
    r.millis = ms[cdum_pkg::OUT_MS_W-1:0];
    return r;
  endfunction

  task automatic add_stamp(input int y, input int mo, input int d, input int h,
                           input int mi, input int s, input int ms, input bit drain);
    stamp_t st;
    st.year = 15'(y);
    st.month = 4'(mo);
    st.day = 5'(d);
    st.hour = 5'(h);
    st.minute = 6'(mi);
    st.second = 6'(s);
    st.millis = 10'(ms);
    st.drain_first = drain;
    stamps_pending = {stamps_pending, st};
  endtask

  task automatic note_failure(input string what);
    bad_count++;
    if (bad_count <= 10) begin
      $display("MISMATCH at cycle %0d: %s", cycles, what);
    end
  endtask

  // Sender: holds an item until it is taken, then either idles or offers the next.
  always @(posedge clk) begin : drive_stamps
    stamp_t nxt;
    stamp_t taken;
    bit fire;
    bit bursty;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      fire = in_valid && in_ready;
      if (fire) begin
        taken.year = in_cal_year;
        taken.month = in_cal_month;
        taken.day = in_cal_day;
        taken.hour = in_clock_hour;
        taken.minute = in_clock_minute;
        taken.second = in_clock_second;
        taken.millis = in_clock_millis;
        taken.drain_first = 1'b0;
        epochs_expected = {epochs_expected, civil_to_epoch(taken)};
        sent_count <= sent_count + 1;
      end
      bursty = (sent_count < total_stamps - QUIET_TAIL) && (((sent_count / 60) % 3) != 2);
      if (in_valid && !fire) begin
        // Item still waiting for acceptance: payload stays put.
      end else if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (stamps_pending.size() != 0 &&
                   !(stamps_pending[0].drain_first && epochs_expected.size() != 0)) begin
        nxt = stamps_pending.pop_front();
        in_cal_year <= nxt.year;
        in_cal_month <= nxt.month;
        in_cal_day <= nxt.day;
        in_clock_hour <= nxt.hour;
        in_clock_minute <= nxt.minute;
        in_clock_second <= nxt.second;
        in_clock_millis <= nxt.millis;
        in_valid <= 1'b1;
        if (bursty && $urandom_range(0, 3) == 0) begin
          gap_left <= $urandom_range(1, 9);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: checks each accepted result against the oldest expectation.
  always @(posedge clk) begin : check_epochs
    epoch_t want;
    bit bursty;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got_count <= got_count + 1;
        if (epochs_expected.size() == 0) begin
          note_failure($sformatf("unexpected result days=%0d millis=%0d",
                                 out_epoch_days, out_epoch_millis));
        end else begin
          want = epochs_expected.pop_front();
          if (out_epoch_days !== want.days || out_epoch_millis !== want.millis) begin
            note_failure($sformatf("days exp %0d got %0d, millis exp %0d got %0d",
                                   want.days, out_epoch_days,
                                   want.millis, out_epoch_millis));
          end
        end
      end
      bursty = (got_count < total_stamps - QUIET_TAIL) && (((got_count / 70) % 3) != 1);
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else if (bursty && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 8);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("civil_datetime_to_unix_ms verification failed");
      $finish;
    end
  end

  initial begin : run
    int y;
    int kind;
    // The epoch itself and the instant just before it.
    add_stamp(1970, 1, 1, 0, 0, 0, 0, 1'b0);
    add_stamp(1969, 12, 31, 23, 59, 59, 999, 1'b0);
    // Ends of the year range used by the random stamps, with a leap second at the top.
    add_stamp(-999, 1, 1, 0, 0, 0, 0, 1'b0);
    add_stamp(9999, 12, 31, 23, 59, 60, 999, 1'b0);
    // Leap days and century rules.
    add_stamp(2000, 2, 29, 12, 30, 30, 500, 1'b0);
    add_stamp(1900, 3, 1, 0, 0, 0, 0, 1'b0);
    add_stamp(1600, 1, 1, 0, 0, 0, 1, 1'b0);
    add_stamp(0, 2, 29, 1, 2, 3, 4, 1'b0);
    // Era boundaries for negative years.
    add_stamp(-1, 3, 1, 0, 0, 0, 0, 1'b0);
    add_stamp(-400, 3, 1, 0, 0, 0, 0, 1'b0);
    add_stamp(-401, 2, 28, 23, 59, 59, 999, 1'b0);
    // Month zero and months past December.
    add_stamp(2024, 0, 15, 6, 0, 0, 0, 1'b0);
    add_stamp(2024, 13, 1, 0, 0, 0, 0, 1'b0);
    add_stamp(2024, 14, 10, 0, 0, 0, 0, 1'b0);
    add_stamp(2024, 15, 31, 0, 0, 0, 0, 1'b0);
    // Day zero and a day past the end of February.
    add_stamp(2023, 3, 0, 0, 0, 0, 0, 1'b0);
    add_stamp(2023, 2, 31, 0, 0, 0, 0, 1'b0);
    // Time fields at their full widths.
    add_stamp(2010, 6, 15, 31, 63, 63, 1023, 1'b0);
    // Years at the extremes of the field, where the outputs wrap.
    add_stamp(16383, 15, 31, 31, 63, 63, 1023, 1'b0);
    add_stamp(-16384, 0, 0, 0, 0, 0, 0, 1'b0);
    add_stamp(-16384, 15, 31, 31, 63, 63, 1023, 1'b0);
    add_stamp(16383, 0, 0, 0, 0, 0, 0, 1'b0);

    for (int i = 0; i < RANDOM_STAMPS; i++) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        if ($urandom_range(0, 3) == 0) begin
          y = 1960 + $urandom_range(0, 80);
        end else begin
          y = int'($urandom_range(0, 10998)) - 999;
        end
        add_stamp(y, $urandom_range(1, 12),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, 31) : $urandom_range(1, 28),
                  $urandom_range(0, 23), $urandom_range(0, 59),
                  ($urandom_range(0, 19) == 0) ? 60 : $urandom_range(0, 59),
                  $urandom_range(0, 999), (i == 200) || (i == 430));
      end else begin
        add_stamp($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                  (i == 200) || (i == 430));
      end
    end
    total_stamps = stamps_pending.size();

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    while (sent_count < total_stamps) @(posedge clk);
    while (epochs_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (bad_count == 0) begin
      $display("civil_datetime_to_unix_ms verification clean");
    end else begin
      $display("civil_datetime_to_unix_ms verification failed");
    end
    $finish;
  end

endmodule
